// ===== sv/rdef_pkg.sv =====
// shared types and constants of the rgb directional edge filter
package rdef_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int DimW      = 13;
  localparam int ChanW     = 8;
  localparam int NumLanes  = 3;
  localparam int PixW      = ChanW * NumLanes;
  localparam int WinSize   = 9;
  localparam int DiffW     = ChanW + 1;
  localparam int SumW      = ChanW + 2;
  localparam int ResW      = 18;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 13;
  localparam int MinDim    = 3;
  localparam int SignedOffset = 127;
  localparam int MidLevel  = 128;
  localparam int FullScale = 255;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegGain        = 3'd2,
    RegAbsMode     = 3'd3,
    RegInvert      = 3'd4
  } cfg_reg_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [PixW-1:0]  pix_t;
  typedef logic [ColW-1:0]  col_t;
  typedef logic [DimW-1:0]  dim_t;
  typedef pix_t  [WinSize-1:0] win_t;
  typedef chan_t [WinSize-1:0] lane_win_t;
  typedef logic signed [ResW-1:0] res_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    col_t col;
    col_t row;
  } meta_t;

endpackage

// ===== sv/rdef_ram.sv =====
// generic single-write, single-read ram with registered read data
module rdef_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rdef_window.sv =====
// position counters, two line stores and the 3x3 pixel window
module rdef_window (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           accept_i,
  input  rdef_pkg::pix_t pix_i,
  input  logic           frame_start_i,
  input  rdef_pkg::dim_t width_i,
  input  rdef_pkg::dim_t height_i,
  output rdef_pkg::win_t win_o,
  output rdef_pkg::meta_t meta_o
);
  import rdef_pkg::*;

  col_t  col_q, row_q, col0, row0;
  dim_t  col_next, row_next;
  meta_t meta0, meta1_q, meta2_q;
  logic  fwd0, fwd1_q;
  pix_t  px1_q, px2_q, mid2_q;
  pix_t  top_rd, mid_rd, top_eff, mid_eff;
  win_t  win_q;

  // stage 0: position of the incoming item
  always_comb begin
    col0 = frame_start_i ? '0 : col_q;
    row0 = frame_start_i ? '0 : row_q;
    col_next = {1'b0, col0} + dim_t'(1);
    row_next = {1'b0, row0} + dim_t'(1);
    meta0.valid = accept_i;
    meta0.emit  = (col0 >= col_t'(2)) && (row0 >= col_t'(2)) &&
                  ({1'b0, col0} < width_i) && ({1'b0, row0} < height_i);
    meta0.last  = ({1'b0, col0} == width_i - dim_t'(1)) &&
                  ({1'b0, row0} == height_i - dim_t'(1));
    meta0.col   = col0;
    meta0.row   = row0;
    fwd0 = meta1_q.valid && (col0 == meta1_q.col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      if (col_next >= width_i) begin
        col_q <= '0;
        row_q <= (row_next >= height_i) ? '0 : row_next[ColW-1:0];
      end else begin
        col_q <= col_next[ColW-1:0];
        row_q <= row0;
      end
    end
  end

  rdef_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
    .clk_i   (clk_i),
    .we_i    (adv_i && meta1_q.valid),
    .waddr_i (meta1_q.col),
    .wdata_i (mid_eff),
    .re_i    (accept_i),
    .raddr_i (col0),
    .rdata_o (top_rd)
  );

  rdef_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
    .clk_i   (clk_i),
    .we_i    (adv_i && meta1_q.valid),
    .waddr_i (meta1_q.col),
    .wdata_i (px1_q),
    .re_i    (accept_i),
    .raddr_i (col0),
    .rdata_o (mid_rd)
  );

  // same column as the item just ahead: take its values directly
  assign top_eff = fwd1_q ? mid2_q : top_rd;
  assign mid_eff = fwd1_q ? px2_q  : mid_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
      fwd1_q  <= 1'b0;
      win_q   <= '0;
    end else if (adv_i) begin
      meta1_q <= meta0;
      fwd1_q  <= accept_i && fwd0;
      meta2_q <= meta1_q;
      if (meta1_q.valid) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= top_eff;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= mid_eff;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= px1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px1_q  <= pix_i;
      px2_q  <= px1_q;
      mid2_q <= mid_eff;
    end
  end

  assign win_o  = win_q;
  assign meta_o = meta2_q;

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (meta1_q.valid && fwd1_q) |-> (meta2_q.valid && meta2_q.col == meta1_q.col))
    else $error("forwarded item has no matching predecessor");

endmodule

// ===== sv/rdef_lane.sv =====
// edge value of one color channel, two register stages
module rdef_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  rdef_pkg::lane_win_t win_i,
  input  rdef_pkg::chan_t     gain_i,
  input  logic                abs_mode_i,
  input  logic                invert_i,
  output rdef_pkg::res_t      res_o
);
  import rdef_pkg::*;

  logic signed [DiffW-1:0] d [4];
  logic signed [SumW-1:0]  s [4];
  logic [DiffW-1:0] dm [4];
  logic [SumW-1:0]  sm [4];
  logic [1:0] di, si;
  logic signed [DiffW-1:0] d_sel_q;
  logic signed [SumW-1:0]  s_sel_q;

  logic signed [ResW-1:0] pd, pd_abs, pd_rnd, pd_half;
  logic signed [ResW:0]   ps, ps_abs, ps_rnd, ps_q4;
  res_t a_d, b_d, a_q, b_q;
  res_t da, db, r;
  logic [ResW-1:0] da_m, db_m;

  // differences and first largest magnitude of each set
  always_comb begin
    d[0] = $signed({1'b0, win_i[8]}) - $signed({1'b0, win_i[0]});
    d[1] = $signed({1'b0, win_i[5]}) - $signed({1'b0, win_i[3]});
    d[2] = $signed({1'b0, win_i[7]}) - $signed({1'b0, win_i[1]});
    d[3] = $signed({1'b0, win_i[2]}) - $signed({1'b0, win_i[6]});
    s[0] = $signed({2'b0, win_i[8]} + {2'b0, win_i[0]} - {1'b0, win_i[4], 1'b0});
    s[1] = $signed({2'b0, win_i[5]} + {2'b0, win_i[3]} - {1'b0, win_i[4], 1'b0});
    s[2] = $signed({2'b0, win_i[7]} + {2'b0, win_i[1]} - {1'b0, win_i[4], 1'b0});
    s[3] = $signed({2'b0, win_i[2]} + {2'b0, win_i[6]} - {1'b0, win_i[4], 1'b0});
    for (int k = 0; k < 4; k++) begin
      dm[k] = d[k][DiffW-1] ? DiffW'(-d[k]) : DiffW'(d[k]);
      sm[k] = s[k][SumW-1] ? SumW'(-s[k]) : SumW'(s[k]);
    end
    di = 2'd0;
    si = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (dm[k] > dm[di]) begin
        di = 2'(k);
      end
      if (sm[k] > sm[si]) begin
        si = 2'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_sel_q <= d[di];
      s_sel_q <= s[si];
    end
  end

  // gain and scaling, division truncates toward zero
  always_comb begin
    pd = $signed({1'b0, gain_i}) * d_sel_q;
    ps = $signed({1'b0, gain_i}) * s_sel_q;
    pd_abs = pd[ResW-1] ? -pd : pd;
    ps_abs = ps[ResW] ? -ps : ps;
    pd_rnd = pd + $signed({{(ResW-1){1'b0}}, pd[ResW-1]});
    pd_half = pd_rnd >>> 1;
    ps_rnd = ps + $signed({{(ResW-1){1'b0}}, ps[ResW], ps[ResW]});
    ps_q4 = ps_rnd >>> 2;
    if (abs_mode_i) begin
      a_d = pd_abs;
      b_d = res_t'(ps_abs >>> 1);
    end else begin
      a_d = pd_half + res_t'(SignedOffset);
      b_d = res_t'(ps_q4) + res_t'(SignedOffset);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // pick the stronger response, then optional inversion
  always_comb begin
    da = res_t'(MidLevel) - a_q;
    db = res_t'(MidLevel) - b_q;
    da_m = da[ResW-1] ? ResW'(-da) : ResW'(da);
    db_m = db[ResW-1] ? ResW'(-db) : ResW'(db);
    if (abs_mode_i) begin
      r = (a_q > b_q) ? a_q : b_q;
    end else begin
      r = (da_m > db_m) ? a_q : b_q;
    end
    res_o = invert_i ? res_t'(FullScale) - r : r;
  end

endmodule

// ===== sv/rgb_directional_edge_filter.sv =====
// rgb directional edge filter: config registers, channel lanes and output merge
// throughput: one item per cycle; the pipeline stalls only while a result waits
// line stores are read once per item with a registered read
// reset clears counters, window, pipeline valid bits and restores register defaults
// line stores are not cleared; border items give no result
module rgb_directional_edge_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdef_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdef_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [11:0]                   out_column_o,
  output logic [11:0]                   out_row_o,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o,
  output logic [2:0]                    wrap_flags_o,
  output logic                          frame_last_o
);
  import rdef_pkg::*;

  dim_t  width_q, height_q, width_eff, height_eff;
  chan_t gain_q, gain_eff;
  logic  abs_q, inv_q;
  logic  adv, accept;
  win_t  win;
  meta_t meta2, meta3_q, meta4_q;
  res_t  lane_res [NumLanes];
  logic  out_valid_q, last_q;
  col_t  col_out_q, row_out_q;
  chan_t chan_out_q [NumLanes];
  logic [NumLanes-1:0] wrap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dim_t'(640);
      height_q <= dim_t'(480);
      gain_q   <= chan_t'(1);
      abs_q    <= 1'b0;
      inv_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFrameWidth:  width_q  <= cfg_data_i[DimW-1:0];
        RegFrameHeight: height_q <= cfg_data_i[DimW-1:0];
        RegGain:        gain_q   <= cfg_data_i[ChanW-1:0];
        RegAbsMode:     abs_q    <= cfg_data_i[0];
        RegInvert:      inv_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = width_q;
    if (width_q < dim_t'(MinDim)) begin
      width_eff = dim_t'(MinDim);
    end else if (width_q > dim_t'(MaxWidth)) begin
      width_eff = dim_t'(MaxWidth);
    end
    height_eff = height_q;
    if (height_q < dim_t'(MinDim)) begin
      height_eff = dim_t'(MinDim);
    end else if (height_q > dim_t'(MaxHeight)) begin
      height_eff = dim_t'(MaxHeight);
    end
    gain_eff = (gain_q == '0) ? chan_t'(1) : gain_q;
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  rdef_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .accept_i      (accept),
    .pix_i         ({blue_in_i, green_in_i, red_in_i}),
    .frame_start_i (frame_start_i),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .win_o         (win),
    .meta_o        (meta2)
  );

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    lane_win_t lane_win;
    for (genvar k = 0; k < WinSize; k++) begin : g_tap
      assign lane_win[k] = win[k][l*ChanW +: ChanW];
    end
    rdef_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (adv),
      .win_i      (lane_win),
      .gain_i     (gain_eff),
      .abs_mode_i (abs_q),
      .invert_i   (inv_q),
      .res_o      (lane_res[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta3_q     <= '0;
      meta4_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      meta3_q     <= meta2;
      meta4_q     <= meta3_q;
      out_valid_q <= meta4_q.valid && meta4_q.emit;
    end
  end

  // merge lane results into the output item
  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_out_q <= meta4_q.col - col_t'(1);
      row_out_q <= meta4_q.row - col_t'(1);
      last_q    <= meta4_q.last;
      for (int l = 0; l < NumLanes; l++) begin
        chan_out_q[l] <= lane_res[l][ChanW-1:0];
        wrap_q[l]     <= lane_res[l][ResW-1] || (lane_res[l][ResW-2:ChanW] != '0);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_column_o = col_out_q;
  assign out_row_o    = row_out_q;
  assign red_out_o    = chan_out_q[0];
  assign green_out_o  = chan_out_q[1];
  assign blue_out_o   = chan_out_q[2];
  assign wrap_flags_o = wrap_q;
  assign frame_last_o = last_q;

  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_column_o != '0 && out_row_o != '0))
    else $error("result item at a border position");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while a result is held");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(meta4_q.valid && meta4_q.emit))
    else $error("result item without a matching pipeline item");

endmodule
